// ----- rtl/ber_tlv_pkg.sv -----
// ----------------------------------------------------------------------------
// ber_tlv_pkg
// Shared constants and types for the BER tag-length header parser: result
// status codes, parse phases and identifier and length field masks.
// ----------------------------------------------------------------------------
package ber_tlv_pkg;

   localparam int STATUS_W          = 3;
   localparam int HDR_LEN_W         = 3;
   localparam int LEN_W             = 32;
   localparam int TAG_W             = 16;
   localparam int MAX_LEN_OCTETS_DF = 4;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK          = 3'd0,
      ST_SHORT_BUF   = 3'd1,
      ST_BAD_TAG     = 3'd2,
      ST_NO_LEN_BYTE = 3'd3,
      ST_BAD_LEN     = 3'd4,
      ST_OVERRUN     = 3'd5
   } status_type;

   typedef enum logic [3:0] {
      PH_IDLE = 4'b0001,
      PH_TAG2 = 4'b0010,
      PH_LEN1 = 4'b0100,
      PH_LENN = 4'b1000
   } phase_type;

   localparam logic [7:0] HIGH_TAG_MASK = 8'h1f;
   localparam logic [7:0] LONG_FORM_BIT = 8'h80;

endpackage

// ----- rtl/ber_tag_length_header_parser_core.sv -----
// ----------------------------------------------------------------------------
// ber_tag_length_header_parser_core
// Parses one ASN.1 BER identifier-and-length header from a byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   The request channel carries one buffer byte per transaction. A transaction
//   with req_start_req high opens a new buffer: it carries the first
//   identifier octet and the total buffer length, and drops any header still
//   being parsed. Following bytes feed the optional second tag byte and the
//   short- or long-form length field (up to MAX_LENGTH_OCTETS octets).
//   Exactly one response transaction is produced per header: the decoded id,
//   tag, class, constructed bit, content length and header length, or an
//   error status with all other fields zero, raised on the byte that reveals
//   it. Bytes after the response are ignored until the next start.
//   Throughput is one byte per cycle; each byte is decoded by the state
//   update logic in the cycle it is taken, and a response appears in the
//   output register on the cycle after the byte that completes the header.
//   When the receiver stalls, the response is held and the request side is
//   stalled only while a held response blocks the output register.
//   Reset (synchronous) returns the parser to idle with the output empty.
// ----------------------------------------------------------------------------
module ber_tag_length_header_parser_core #(
   parameter int MAX_LENGTH_OCTETS = ber_tlv_pkg::MAX_LEN_OCTETS_DF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_start_req,
   input  logic [7:0]                          req_data_byte,
   input  logic [ber_tlv_pkg::LEN_W-1:0]       req_buffer_len,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [ber_tlv_pkg::STATUS_W-1:0]    rsp_status,
   output logic [7:0]                          rsp_id_octet,
   output logic [ber_tlv_pkg::TAG_W-1:0]       rsp_tag_value,
   output logic [1:0]                          rsp_tag_class,
   output logic                                rsp_constructed,
   output logic [ber_tlv_pkg::LEN_W-1:0]       rsp_content_len,
   output logic [ber_tlv_pkg::HDR_LEN_W-1:0]   rsp_header_len
);
   import ber_tlv_pkg::*;

   localparam int SEEN_W = $clog2(MAX_LENGTH_OCTETS + 4);
   localparam int LEFT_W = $clog2(MAX_LENGTH_OCTETS + 1);

   phase_type           phase_ff, phase_in;
   logic [LEN_W-1:0]    limit_ff, limit_in;
   logic [SEEN_W-1:0]   seen_ff, seen_in, seen_inc;
   logic [7:0]          id_ff, id_in;
   logic [TAG_W-1:0]    tag_ff, tag_in;
   logic [LEN_W-1:0]    accum_ff, accum_in;
   logic [LEFT_W-1:0]   left_ff, left_in, left_dec;

   logic                req_accept;
   logic                emit_err, do_final, emit;
   status_type          err_code, res_status;
   logic [6:0]          len_n;
   logic                overrun;

   logic                rsp_valid_ff;
   status_type          status_ff, status_in;
   logic [7:0]          rid_ff, rid_in;
   logic [TAG_W-1:0]    rtag_ff, rtag_in;
   logic [LEN_W-1:0]    rlen_ff, rlen_in;
   logic [HDR_LEN_W-1:0] rhdr_ff, rhdr_in;

   assign req_stall  = rsp_valid_ff & rsp_stall;
   assign req_accept = req_valid & ~req_stall;

   assign len_n    = req_data_byte[6:0];
   assign seen_inc = seen_ff + 1'b1;
   assign left_dec = (left_ff != '0) ? left_ff - 1'b1 : left_ff;

   // Parse step for one byte
   always_comb begin
      phase_in = phase_ff;
      limit_in = limit_ff;
      seen_in  = seen_ff;
      id_in    = id_ff;
      tag_in   = tag_ff;
      accum_in = accum_ff;
      left_in  = left_ff;
      emit_err = 1'b0;
      err_code = ST_OK;
      do_final = 1'b0;

      if (req_start_req) begin
         limit_in = req_buffer_len;
         accum_in = '0;
         left_in  = '0;
         if (req_buffer_len < LEN_W'(2)) begin
            emit_err = 1'b1;
            err_code = ST_SHORT_BUF;
         end else begin
            id_in   = req_data_byte;
            tag_in  = TAG_W'(req_data_byte);
            seen_in = SEEN_W'(1);
            phase_in = ((req_data_byte & HIGH_TAG_MASK) == HIGH_TAG_MASK) ? PH_TAG2
                                                                           : PH_LEN1;
         end
      end else begin
         case (phase_ff)
            PH_IDLE: begin
            end
            PH_TAG2: begin
               if (req_data_byte[7]) begin
                  emit_err = 1'b1;
                  err_code = ST_BAD_TAG;
               end else begin
                  tag_in  = {id_ff, req_data_byte};
                  seen_in = SEEN_W'(2);
                  if (limit_ff <= LEN_W'(2)) begin
                     emit_err = 1'b1;
                     err_code = ST_NO_LEN_BYTE;
                  end else begin
                     phase_in = PH_LEN1;
                  end
               end
            end
            PH_LEN1: begin
               seen_in = seen_inc;
               if (!req_data_byte[7]) begin
                  accum_in = LEN_W'(len_n);
                  do_final = 1'b1;
               end else if ((len_n > 7'(MAX_LENGTH_OCTETS)) ||
                            ((33'(seen_inc) + 33'(len_n)) > {1'b0, limit_ff})) begin
                  emit_err = 1'b1;
                  err_code = ST_BAD_LEN;
               end else begin
                  accum_in = '0;
                  if (len_n == 7'd0) begin
                     do_final = 1'b1;
                  end else begin
                     left_in  = LEFT_W'(len_n);
                     phase_in = PH_LENN;
                  end
               end
            end
            PH_LENN: begin
               accum_in = {accum_ff[LEN_W-9:0], req_data_byte};
               seen_in  = seen_inc;
               left_in  = left_dec;
               if (left_dec == '0) begin
                  do_final = 1'b1;
               end
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end

      if (emit_err || do_final) begin
         phase_in = PH_IDLE;
      end
   end

   // Content bound, widened so the sum cannot wrap
   assign overrun = (33'(seen_in) + {1'b0, accum_in}) > {1'b0, limit_ff};
   assign emit    = emit_err | do_final;

   always_comb begin
      if (emit_err) begin
         res_status = err_code;
      end else if (overrun) begin
         res_status = ST_OVERRUN;
      end else begin
         res_status = ST_OK;
      end
      status_in = res_status;
      if (res_status == ST_OK) begin
         rid_in  = id_in;
         rtag_in = tag_in;
         rlen_in = accum_in;
         rhdr_in = seen_in[HDR_LEN_W-1:0];
      end else begin
         rid_in  = '0;
         rtag_in = '0;
         rlen_in = '0;
         rhdr_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         limit_ff <= '0;
         seen_ff  <= '0;
         id_ff    <= '0;
         tag_ff   <= '0;
         accum_ff <= '0;
         left_ff  <= '0;
      end else if (req_accept) begin
         phase_ff <= phase_in;
         limit_ff <= limit_in;
         seen_ff  <= seen_in;
         id_ff    <= id_in;
         tag_ff   <= tag_in;
         accum_ff <= accum_in;
         left_ff  <= left_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept && emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Load the result register only when a response is emitted; hold otherwise
   always_ff @(posedge clock) begin
      if (req_accept && emit) begin
         status_ff <= status_in;
         rid_ff    <= rid_in;
         rtag_ff   <= rtag_in;
         rlen_ff   <= rlen_in;
         rhdr_ff   <= rhdr_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_id_octet    = rid_ff;
   assign rsp_tag_value   = rtag_ff;
   assign rsp_tag_class   = rid_ff[7:6];
   assign rsp_constructed = rid_ff[5];
   assign rsp_content_len = rlen_ff;
   assign rsp_header_len  = rhdr_ff;

   a_short_buf_error : assert property (@(posedge clock) disable iff (reset)
      req_accept && req_start_req && (req_buffer_len < LEN_W'(2))
      |=> rsp_valid && (rsp_status == ST_SHORT_BUF))
      else $error("short buffer did not raise an error response");

   a_error_fields_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_OK)
      |-> (rsp_content_len == '0) && (rsp_header_len == '0) && (rsp_id_octet == '0))
      else $error("error response carries non-zero fields");

   a_lenn_has_octets : assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_LENN) |-> (left_ff != '0))
      else $error("long-form length phase with no octets left");

   a_idle_byte_silent : assert property (@(posedge clock) disable iff (reset)
      req_accept && !req_start_req && (phase_ff == PH_IDLE) && !rsp_stall
      |=> !rsp_valid)
      else $error("byte taken while idle produced a response");

endmodule
